>>> rtl/core/klv_caption_essence_extractor_assert.svh
// assertion macros for the klv caption essence extractor
// used by kce_front and kce_back; no other dependencies
`ifndef KLV_CAPTION_ESSENCE_EXTRACTOR_ASSERT_SVH
`define KLV_CAPTION_ESSENCE_EXTRACTOR_ASSERT_SVH

// property that must hold at every clock edge once out of reset
`define KCE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define KCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/kce_pkg.sv
// shared types and constants for the klv caption essence extractor
// no dependencies
package kce_pkg;

    localparam logic [1:0] EV_CC    = 2'd0;
    localparam logic [1:0] EV_END   = 2'd1;
    localparam logic [1:0] EV_LENER = 2'd2;

    localparam logic [1:0] CFG_ANC_MODE  = 2'd0;
    localparam logic [1:0] CFG_KEY_VALID = 2'd1;
    localparam logic [1:0] CFG_TRACK     = 2'd2;

    localparam logic [7:0] DID_A   = 8'h61;
    localparam logic [7:0] DID_B   = 8'h80;
    localparam logic [7:0] CDP_ID0 = 8'h96;
    localparam logic [7:0] CDP_ID1 = 8'h69;
    localparam logic [7:0] CDP_SEC = 8'h72;
    localparam logic [7:0] SYNC0   = 8'h06;
    localparam int unsigned MIN_ELEM = 19;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  data_byte;
        logic [3:0]  frame_rate_code;
        logic [31:0] element_index;
        logic        element_last;
    } result_t;

    localparam int unsigned RES_W = $bits(result_t);

    function automatic logic [7:0] key_byte(input logic [3:0] idx);
        logic [7:0] r;
        begin
            unique case (idx)
                4'd0: r = 8'h06;
                4'd1: r = 8'h0e;
                4'd2: r = 8'h2b;
                4'd3: r = 8'h34;
                4'd4: r = 8'h01;
                4'd5: r = 8'h02;
                4'd6: r = 8'h01;
                4'd7: r = 8'h01;
                4'd8: r = 8'h0d;
                4'd9: r = 8'h01;
                4'd10: r = 8'h03;
                default: r = 8'h01;
            endcase
            return r;
        end
    endfunction

endpackage

>>> rtl/core/klv_caption_essence_extractor.sv
// top level of the klv caption essence extractor
// depends on kce_pkg, kce_front, kce_back
// Takes one container byte per item on s_axis and emits caption bytes, element-end and
// length-error items on m_axis. Throughput is one byte per clock while results are read:
// the parser state updates once per byte in the back part, and a two-entry queue decouples
// input from the parser. A one-entry output register holds each result. The parser takes
// the next byte whenever that register is empty or is being read in the same cycle. While
// a result waits unread, the parser stalls and the queue absorbs up to two more bytes. An
// input byte is registered in the queue before the parser takes it, and each result is
// registered in the output register. Configuration writes on the cfg channel are taken at
// any time but must only be issued while the block is idle.
module klv_caption_essence_extractor
    import kce_pkg::*;
#(
    parameter int unsigned MAX_LENGTH_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // stream_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // event_res, data_byte, frame_rate_code, element_index
    output logic        m_axis_tlast,   // element_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic        anc_reg, kv_reg;
    logic [31:0] trk_reg;
    logic        q_valid, q_ready;
    logic [7:0]  q_byte;
    result_t     res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anc_reg <= 1'b0;
            kv_reg  <= 1'b0;
            trk_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_ANC_MODE) anc_reg <= cfg_data[0];
            else if (cfg_index == CFG_KEY_VALID) kv_reg <= cfg_data[0];
            else if (cfg_index == CFG_TRACK) trk_reg <= cfg_data;
        end
    end

    kce_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_byte(s_axis_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_byte(q_byte)
    );

    kce_back #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_byte(q_byte),
        .anc_mode(anc_reg), .key_valid(kv_reg), .track(trk_reg),
        .o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {2'd0, res.element_index, res.frame_rate_code,
                           res.data_byte, res.event_res};
    assign m_axis_tlast = res.element_last;
endmodule

>>> rtl/core/kce_front.sv
// front part: accepts stream bytes and registers them into a short queue
// depends on kce_pkg
module kce_front
    import kce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       q_valid,
    input  logic       q_ready,
    output logic [7:0] q_byte
);
    // two-entry queue
    logic [7:0] mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_byte   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_byte;
        end
    end

`include "klv_caption_essence_extractor_assert.svh"
    `KCE_ASSERT(a_cnt_range, cnt_reg != 2'd3)
    `KCE_ASSERT_NEXT(a_full_push, (cnt_reg == 2'd2) && !pop, cnt_reg == 2'd2)
    `KCE_ASSERT(a_ptr_cnt, (cnt_reg != 2'd0 && cnt_reg != 2'd2) || wp_reg == rp_reg)
endmodule

>>> rtl/core/kce_back.sv
// back part: klv parser state machine with a one-entry output skid
// depends on kce_pkg
module kce_back
    import kce_pkg::*;
#(
    parameter int unsigned MAX_LENGTH_BYTES = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  logic [7:0]    q_byte,
    input  logic          anc_mode,
    input  logic          key_valid,
    input  logic [31:0]   track,
    output logic          o_valid,
    input  logic          o_ready,
    output result_t       o_res
);
    typedef enum logic [11:0] {
        PH_SYNC    = 12'b000000000001,
        PH_KEY     = 12'b000000000010,
        PH_BER     = 12'b000000000100,
        PH_BERLONG = 12'b000000001000,
        PH_SKIP    = 12'b000000010000,
        PH_HDR     = 12'b000000100000,
        PH_DID     = 12'b000001000000,
        PH_SDID    = 12'b000010000000,
        PH_CSIZE   = 12'b000100000000,
        PH_CDP     = 12'b001000000000,
        PH_CC      = 12'b010000000000,
        PH_CDPSKIP = 12'b100000000000
    } phase_t;

    phase_t      ph_reg, ph_next;
    logic [3:0]  mc_reg, mc_next;
    logic        ke_reg, ke_next;
    logic [3:0]  bl_reg, bl_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] cons_reg, cons_next;
    logic [7:0]  apl_reg, apl_next;
    logic [7:0]  csz_reg, csz_next;
    logic [8:0]  ccons_reg, ccons_next;
    logic [6:0]  ccl_reg, ccl_next;
    logic [3:0]  rate_reg, rate_next;
    logic [31:0] ecnt_reg, ecnt_next;
    logic        ov_reg;
    result_t     ores_reg;

    logic        take, emit;
    result_t     res;
    logic        ended, is_cc;
    logic [63:0] cinc;
    logic [8:0]  cdp_inc;
    logic [7:0]  exp_b;
    logic [7:0]  b;
    logic [7:0]  ccount;

    assign b       = q_byte;
    assign q_ready = !ov_reg || o_ready;
    assign take    = q_valid && q_ready;
    assign o_valid = ov_reg;
    assign o_res   = ores_reg;
    assign cinc    = cons_reg + 64'd1;
    assign cdp_inc = ccons_reg + 9'd1;
    assign ccount  = {3'd0, b[4:0]} + {2'd0, b[4:0], 1'b0};

    always_comb
    begin
        unique case (mc_reg)
            4'd12: exp_b = track[31:24];
            4'd13: exp_b = track[23:16];
            4'd14: exp_b = track[15:8];
            4'd15: exp_b = track[7:0];
            default: exp_b = key_byte(mc_reg);
        endcase
    end

    always_comb
    begin
        logic        fin_done, kq;
        logic [7:0]  apl_dec;
        ph_next = ph_reg; mc_next = mc_reg; ke_next = ke_reg; bl_next = bl_reg;
        len_next = len_reg; cons_next = cons_reg; apl_next = apl_reg; csz_next = csz_reg;
        ccons_next = ccons_reg; ccl_next = ccl_reg; rate_next = rate_reg;
        ended = 1'b0; is_cc = 1'b0; emit = 1'b0;
        res = '0;
        fin_done = 1'b0; kq = 1'b0;
        apl_dec = apl_reg - 8'd1;
        unique case (ph_reg)
            PH_SYNC:
            begin
                if (b == SYNC0) mc_next = 4'd1;
                else if (mc_reg < 4'd4 && b == key_byte(mc_reg)) mc_next = mc_reg + 4'd1;
                else mc_next = 4'd0;
                if (mc_next >= 4'd4)
                begin
                    ph_next = PH_KEY;
                    ke_next = 1'b1;
                end
            end
            PH_KEY:
            begin
                if (b != exp_b) ke_next = 1'b0;
                if (mc_reg == 4'd15) ph_next = PH_BER;
                else mc_next = mc_reg + 4'd1;
            end
            PH_BER, PH_BERLONG:
            begin
                logic        start;
                logic [63:0] nl;
                start = 1'b0;
                nl = len_reg;
                if (ph_reg == PH_BER)
                begin
                    if (b[7])
                    begin
                        if (b[6:0] > 7'(MAX_LENGTH_BYTES))
                        begin
                            ph_next = PH_SYNC;
                            mc_next = 4'd0;
                            emit = 1'b1;
                            res.event_res = EV_LENER;
                            res.frame_rate_code = rate_reg;
                        end
                        else if (b[6:0] != 7'd0)
                        begin
                            nl = '0;
                            bl_next = b[3:0];
                            ph_next = PH_BERLONG;
                        end
                        else
                        begin
                            nl = '0;
                            start = 1'b1;
                        end
                    end
                    else
                    begin
                        nl = {56'd0, b};
                        start = 1'b1;
                    end
                end
                else
                begin
                    nl = {len_reg[55:0], b};
                    bl_next = bl_reg - 4'd1;
                    start = (bl_next == 4'd0);
                end
                len_next = nl;
                if (start)
                begin
                    cons_next = '0;
                    kq = ke_reg && key_valid && anc_mode;
                    ke_next = kq;
                    if (kq)
                    begin
                        if (nl < 64'(MIN_ELEM))
                        begin
                            // zero consumed: ends here when length is zero, else skips the body
                            if (nl == 64'd0)
                            begin
                                ph_next = PH_SYNC; mc_next = 4'd0; ended = 1'b1;
                            end
                            else ph_next = PH_SKIP;
                        end
                        else ph_next = PH_HDR;
                    end
                    else if (nl == 64'd0)
                    begin
                        ph_next = PH_SYNC; mc_next = 4'd0;
                    end
                    else ph_next = PH_SKIP;
                end
            end
            default:
            begin
                cons_next = cinc;
                fin_done = (cinc >= len_reg);
                unique case (ph_reg)
                    PH_SKIP:
                    begin
                        if (fin_done)
                        begin
                            ph_next = PH_SYNC; mc_next = 4'd0; ended = ke_reg;
                        end
                    end
                    PH_HDR:
                    begin
                        logic [7:0] a;
                        a = apl_reg;
                        if (cinc == 64'd2) begin a = b; apl_next = b; end
                        if (cinc >= 64'd16)
                        begin
                            if (a == 8'd0)
                            begin
                                if (fin_done) begin ph_next = PH_SYNC; mc_next = 4'd0; ended = 1'b1; end
                                else ph_next = PH_SKIP;
                            end
                            else ph_next = PH_DID;
                        end
                    end
                    PH_DID:
                    begin
                        if (b == DID_A || b == DID_B) ph_next = PH_SDID;
                        else if (fin_done) begin ph_next = PH_SYNC; mc_next = 4'd0; ended = 1'b1; end
                        else ph_next = PH_SKIP;
                    end
                    PH_SDID: ph_next = PH_CSIZE;
                    PH_CSIZE:
                    begin
                        csz_next = b;
                        if ({56'd0, b} + 64'(MIN_ELEM) > len_reg)
                        begin
                            if (fin_done) begin ph_next = PH_SYNC; mc_next = 4'd0; ended = 1'b1; end
                            else ph_next = PH_SKIP;
                        end
                        else
                        begin
                            ccons_next = '0;
                            ph_next = PH_CDP;
                        end
                    end
                    default:
                    begin
                        // cdp body and caption bytes share the tail logic; cdp skip shares the done logic
                        logic tail, done;
                        tail = 1'b0; done = 1'b0;
                        ccons_next = cdp_inc;
                        if (ph_reg == PH_CDP)
                        begin
                            if (ccons_reg == 9'd0) ccl_next = {6'd0, b == CDP_ID0};
                            else if (ccons_reg == 9'd1)
                            begin
                                ccl_next = '0;
                                if (!(ccl_reg[0] && b == CDP_ID1)) tail = 1'b1;
                            end
                            else if (ccons_reg == 9'd2) tail = (b != csz_reg);
                            else if (ccons_reg == 9'd3) rate_next = b[7:4];
                            else if (ccons_reg == 9'd7) tail = (b != CDP_SEC);
                            else if (ccons_reg >= 9'd8)
                            begin
                                ccl_next = ccount[6:0];
                                if (ccount[6:0] != 7'd0) ph_next = PH_CC;
                                else tail = 1'b1;
                            end
                        end
                        else if (ph_reg == PH_CC)
                        begin
                            is_cc = 1'b1;
                            ccl_next = ccl_reg - 7'd1;
                            tail = (ccl_next == 7'd0);
                        end
                        else if (ph_reg == PH_CDPSKIP)
                        begin
                            done = (cdp_inc >= {1'b0, csz_reg});
                        end
                        else
                        begin
                            ph_next = PH_SYNC; mc_next = 4'd0;
                        end
                        if (tail)
                        begin
                            if (cdp_inc >= {1'b0, csz_reg}) done = 1'b1;
                            else ph_next = PH_CDPSKIP;
                        end
                        if (done)
                        begin
                            apl_next = apl_dec;
                            if (apl_dec == 8'd0)
                            begin
                                if (fin_done) begin ph_next = PH_SYNC; mc_next = 4'd0; ended = 1'b1; end
                                else ph_next = PH_SKIP;
                            end
                            else ph_next = PH_DID;
                        end
                    end
                endcase
            end
        endcase
        if (is_cc)
        begin
            emit = 1'b1;
            res.event_res = EV_CC;
            res.data_byte = b;
            res.frame_rate_code = rate_next;
            res.element_index = ecnt_reg;
            res.element_last = ended;
        end
        else if (ended)
        begin
            emit = 1'b1;
            res.event_res = EV_END;
            res.frame_rate_code = rate_next;
            res.element_index = ecnt_reg;
            res.element_last = 1'b1;
        end
        ecnt_next = ended ? ecnt_reg + 32'd1 : ecnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_SYNC; mc_reg <= '0; ke_reg <= 1'b1; bl_reg <= '0;
            len_reg <= '0; cons_reg <= '0; apl_reg <= '0; csz_reg <= '0;
            ccons_reg <= '0; ccl_reg <= '0; rate_reg <= '0; ecnt_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                ph_reg <= ph_next; mc_reg <= mc_next; ke_reg <= ke_next; bl_reg <= bl_next;
                len_reg <= len_next; cons_reg <= cons_next; apl_reg <= apl_next;
                csz_reg <= csz_next; ccons_reg <= ccons_next; ccl_reg <= ccl_next;
                rate_reg <= rate_next; ecnt_reg <= ecnt_next;
            end
            if (take) ov_reg <= emit;
            else if (o_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit) ores_reg <= res;
    end

`include "klv_caption_essence_extractor_assert.svh"
    `KCE_ASSERT(a_ph_onehot, $onehot(ph_reg))
    `KCE_ASSERT_NEXT(a_cnt_step, take && ended, ecnt_reg == $past(ecnt_reg) + 32'd1)
    `KCE_ASSERT_NEXT(a_hold, ov_reg && !o_ready, ov_reg && $stable(ores_reg))
endmodule
